>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/tcl_pkg.sv
package tcl_pkg;

    localparam logic [1:0] KIND_IDENT = 2'd0;
    localparam logic [1:0] KIND_CONST = 2'd1;
    localparam logic [1:0] KIND_OPER  = 2'd2;

    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_PERCENT   = 8'h25;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_lex_in;

    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] token_char;
        logic       token_end;
        logic       run_end;
    } t_lex_out;

    typedef struct packed {
        logic letter;
        logic digit;
        logic underscore;
        logic oper;
    } t_char_class;

endpackage

>>> hdl/tcl_char_class.sv
module tcl_char_class (
    input  logic [7:0]           i_char,
    output tcl_pkg::t_char_class o_class
);

    always_comb begin
        o_class.letter = ((i_char >= tcl_pkg::CH_LOWER_A) && (i_char <= tcl_pkg::CH_LOWER_Z))
                      || ((i_char >= tcl_pkg::CH_UPPER_A) && (i_char <= tcl_pkg::CH_UPPER_Z));
        o_class.digit  = (i_char >= tcl_pkg::CH_DIGIT_0) && (i_char <= tcl_pkg::CH_DIGIT_9);
        o_class.underscore = (i_char == tcl_pkg::CH_UNDERSCORE);
        o_class.oper   = (i_char == tcl_pkg::CH_PLUS)  || (i_char == tcl_pkg::CH_MINUS)
                      || (i_char == tcl_pkg::CH_STAR)  || (i_char == tcl_pkg::CH_SLASH)
                      || (i_char == tcl_pkg::CH_EQUAL) || (i_char == tcl_pkg::CH_PERCENT);
    end

endmodule

>>> hdl/token_classifier_lexer.sv
// Byte-serial tokenizer. A byte that extends an open identifier or constant
// is written into the token buffer, a RAM of TOKEN_MAX-1 bytes with a
// registered read port, and the block stays ready for the next byte. A byte
// that is dropped also leaves it ready. A byte that starts a token or is an
// operator, with no token to close, passes through ST_TAIL before the next
// byte is taken. When a token closes, the block stops taking requests and
// streams the stored characters out through the RAM read port, one result
// per cycle while the output is not stalled. When the closing byte starts a
// new token, that token's first character is written in ST_TAIL after the
// reads. When the byte is an operator or a one-character token flushed at
// end of text, its result waits in ST_TAIL for the last read to leave the
// read register. Tokens longer than TOKEN_MAX-1 characters are cut to that
// length. The buffer needs no clearing after reset; only characters written
// for the open token are read.
`include "assert_macros.svh"

module token_classifier_lexer #(
    parameter int TOKEN_MAX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcl_pkg::t_lex_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tcl_pkg::t_lex_out o_out_data
);

    localparam int DEPTH = TOKEN_MAX - 1;
    localparam int LEN_W = $clog2(TOKEN_MAX);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_CONST = 2'd2
    } t_scan_mode;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_TAIL = 3'b100
    } t_seq_state;

    tcl_pkg::t_char_class w_cls;

    tcl_char_class u_cls (
        .i_char  (i_in_data.char_code),
        .o_class (w_cls)
    );

    // Control state.
    t_seq_state       r_state,   n_state;
    t_scan_mode       r_mode,    n_mode;
    logic [LEN_W-1:0] r_len,     n_len;
    logic             r_rd_pend, n_rd_pend;
    logic             r_out_valid, n_out_valid;

    // Payload and plan registers.
    logic [7:0]        r_char,        n_char;
    t_scan_mode        r_new_mode,    n_new_mode;
    logic              r_direct,      n_direct;
    logic              r_write,       n_write;
    logic [1:0]        r_direct_kind, n_direct_kind;
    logic [LEN_W-1:0]  r_rd_len,      n_rd_len;
    logic [1:0]        r_rd_kind,     n_rd_kind;
    logic              r_rd_last_run, n_rd_last_run;
    logic [LEN_W-1:0]  r_idx,         n_idx;
    logic              r_rd_tok_end,  n_rd_tok_end;
    logic              r_rd_run_end,  n_rd_run_end;
    logic [1:0]        r_rd_dkind,    n_rd_dkind;
    tcl_pkg::t_lex_out r_out,         n_out;

    // Token buffer.
    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;

    logic             in_acc;
    logic             cont;
    logic             closing;
    logic             new_start;
    logic             op_hit;
    logic             last;
    logic             tail_direct;
    logic             tail_write;
    logic [LEN_W-1:0] len_inc;
    logic             out_free;
    logic             rd_take;
    logic             direct_take;
    logic             rd_issue;
    logic             last_read;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc = i_in_valid & o_in_ready;
    assign last   = i_in_data.end_of_text;

    always_comb begin
        cont = ((r_mode == MODE_IDENT) && (w_cls.letter || w_cls.digit || w_cls.underscore))
            || ((r_mode == MODE_CONST) && w_cls.digit);
        closing     = (r_mode != MODE_IDLE) && !cont;
        // A byte that does not extend the open token is handled as if none were open.
        new_start   = !cont && (w_cls.letter || w_cls.digit);
        op_hit      = !cont && w_cls.oper;
        tail_direct = op_hit || (new_start && last);
        tail_write  = new_start && !last;
        len_inc     = (r_len < DEPTH_L) ? (r_len + LEN_W'(1)) : r_len;
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign rd_take     = out_free && r_rd_pend;
    assign direct_take = out_free && !r_rd_pend && (r_state == ST_TAIL) && r_direct;
    assign rd_issue    = (r_state == ST_READ) && (!r_rd_pend || out_free);
    assign last_read   = ((r_idx + LEN_W'(1)) == r_rd_len);
    assign mem_re      = rd_issue;

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_len         = r_len;
        n_char        = r_char;
        n_new_mode    = r_new_mode;
        n_direct      = r_direct;
        n_write       = r_write;
        n_direct_kind = r_direct_kind;
        n_rd_len      = r_rd_len;
        n_rd_kind     = r_rd_kind;
        n_rd_last_run = r_rd_last_run;
        n_idx         = r_idx;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_char        = i_in_data.char_code;
                    n_direct      = tail_direct;
                    n_write       = tail_write;
                    n_new_mode    = w_cls.letter ? MODE_IDENT : MODE_CONST;
                    n_direct_kind = w_cls.oper ? tcl_pkg::KIND_OPER :
                                    (w_cls.letter ? tcl_pkg::KIND_IDENT : tcl_pkg::KIND_CONST);
                    n_idx         = '0;
                    n_rd_kind     = (r_mode == MODE_CONST) ? tcl_pkg::KIND_CONST
                                                           : tcl_pkg::KIND_IDENT;
                    if (closing) begin
                        n_rd_len      = r_len;
                        n_rd_last_run = !tail_direct;
                        n_mode        = MODE_IDLE;
                        n_len         = '0;
                        n_state       = ST_READ;
                    end else if (cont) begin
                        if (r_len < DEPTH_L) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_len[IDX_W-1:0];
                            mem_wdata = i_in_data.char_code;
                        end
                        if (last) begin
                            // The write lands before the first read of the flush.
                            n_rd_len      = len_inc;
                            n_rd_last_run = 1'b1;
                            n_mode        = MODE_IDLE;
                            n_len         = '0;
                            n_state       = ST_READ;
                        end else begin
                            n_len = len_inc;
                        end
                    end else if (tail_direct || tail_write) begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_READ: begin
                if (rd_issue) begin
                    n_idx = r_idx + LEN_W'(1);
                    if (last_read) begin
                        n_state = (r_direct || r_write) ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (r_write) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = r_char;
                    n_mode    = r_new_mode;
                    n_len     = LEN_W'(1);
                    n_state   = ST_IDLE;
                end else if (direct_take || !r_direct) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Read data register and its tags, plus the output register.
    always_comb begin
        n_rd_pend    = r_rd_pend;
        n_rd_tok_end = r_rd_tok_end;
        n_rd_run_end = r_rd_run_end;
        n_rd_dkind   = r_rd_dkind;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (rd_issue) begin
            n_rd_pend    = 1'b1;
            n_rd_tok_end = last_read;
            n_rd_run_end = last_read && r_rd_last_run;
            n_rd_dkind   = r_rd_kind;
        end else if (rd_take) begin
            n_rd_pend = 1'b0;
        end

        if (rd_take) begin
            n_out_valid      = 1'b1;
            n_out.token_kind = r_rd_dkind;
            n_out.token_char = r_rd_data;
            n_out.token_end  = r_rd_tok_end;
            n_out.run_end    = r_rd_run_end;
        end else if (direct_take) begin
            n_out_valid      = 1'b1;
            n_out.token_kind = r_direct_kind;
            n_out.token_char = r_char;
            n_out.token_end  = 1'b1;
            n_out.run_end    = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_IDLE;
            r_len       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_len       <= n_len;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char        <= n_char;
        r_new_mode    <= n_new_mode;
        r_direct      <= n_direct;
        r_write       <= n_write;
        r_direct_kind <= n_direct_kind;
        r_rd_len      <= n_rd_len;
        r_rd_kind     <= n_rd_kind;
        r_rd_last_run <= n_rd_last_run;
        r_idx         <= n_idx;
        r_rd_tok_end  <= n_rd_tok_end;
        r_rd_run_end  <= n_rd_run_end;
        r_rd_dkind    <= n_rd_dkind;
        r_out         <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    `TCL_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= DEPTH_L)
    `TCL_ASSERT_IMPL(a_idle_len_zero, i_clk, i_rst_n, r_mode == MODE_IDLE, r_len == '0)
    `TCL_ASSERT_IMPL(a_open_len_nonzero, i_clk, i_rst_n, r_mode != MODE_IDLE, r_len != '0)
    `TCL_ASSERT_IMPL(a_run_end_on_tok_end, i_clk, i_rst_n,
                     o_out_valid && o_out_data.run_end, o_out_data.token_end)
    `TCL_ASSERT_NEXT(a_read_ends, i_clk, i_rst_n, rd_issue && last_read, r_state != ST_READ)

endmodule
